// ===== sv/assert_macros.svh =====
// Assertion macros shared by the caption triplet batcher modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, idle while reset is applied
`define CTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds
`define CTB_ASSERT_NEVER(lbl, expr, msg) \
	`CTB_ASSERT(lbl, !(expr), msg)

`endif

// ===== sv/ctb_pkg.sv =====
// Shared types and constants of the caption triplet batcher
`default_nettype none

package ctb_pkg;

	// Top six bits of the first byte that mark a valid caption triplet
	localparam logic [5:0] MARKER_BITS = 6'h3F;

	// Input selector carried on s_tuser
	localparam logic MODE_TRIPLET   = 1'b0;
	localparam logic MODE_FRAME_END = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ctb_state_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic item_valid;  // an input transaction is offered
		logic item_frame;  // the offered item is a frame end
		logic release_hit; // a frame end now would release triplets
		logic slot_free;   // the output register can take a result this cycle
		logic last_emit;   // the next emitted triplet closes the batch
	} ctb_sts_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic ready;        // take an input transaction
		logic take_triplet; // queue (or drop) a caption triplet
		logic take_frame;   // handle a frame end
		logic emit;         // move one fetched triplet into the output register
	} ctb_cmd_t;

endpackage

`default_nettype wire

// ===== sv/caption_triplet_batcher.sv =====
// Top level of the caption triplet batcher
//
// Input channel s_*: one transaction is either a caption triplet (s_tuser = 0) or an
// end of frame (s_tuser = 1). s_tdata carries cc_byte0, cc_byte1, cc_byte2 from the
// lowest byte up; it is ignored for a frame end. A triplet whose first byte has its top
// six bits set is queued; others are ignored. A full queue drops it and flags this.
// Output channel m_*: m_tdata carries out_byte0..2, m_tuser has_triplet, flushed,
// dropped_full from bit 0 up, m_tlast marks the final result of a frame end.
// A triplet gives one result, visible the cycle after acceptance; the next item is taken
// in that same cycle if the receiver takes the result, so triplets run at one a cycle.
// A frame end that releases a batch of n triplets (n up to BATCH_TRIPLETS) reads its
// first triplet into a read register, then into the output register, then one more result
// each cycle while the receiver takes them; no input is taken until the batch has left.
// A frame end that releases nothing gives one empty result with m_tlast set.
// When the receiver stalls, the output register holds its result and no further item
// is accepted. Reset clears pointers, fill count and frame counter and sets the ratio
// to 1; the queue memory is not cleared, and no entry is read before it is written.
// Configuration: cfg_valid/cfg_data write the frame ratio; cfg_ready is always high.
`default_nettype none

module caption_triplet_batcher #(
	parameter int QUEUE_DEPTH    = 512,
	parameter int BATCH_TRIPLETS = 20,
	parameter int FLUSH_LIMIT    = 320
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // cc_byte0 [7:0], cc_byte1 [15:8], cc_byte2 [23:16]
	input  wire logic [0:0]  s_tuser,   // mode [0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // out_byte0 [7:0], out_byte1 [15:8], out_byte2 [23:16]
	output logic [2:0]       m_tuser,   // has_triplet [0], flushed [1], dropped_full [2]
	output logic             m_tlast,   // last_of_frame
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data   // frame_ratio
);

	ctb_pkg::ctb_cmd_t cmd;
	ctb_pkg::ctb_sts_t sts;

	// Ratio writes land at once; the user must write them only while the block is idle, which the block does not enforce
	assign cfg_ready = 1'b1;
	assign s_tready  = cmd.ready;

	// Sequence accepts and drains
	ctb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Hold the queue, counters and the output register
	ctb_datapath #(
		.QUEUE_DEPTH    (QUEUE_DEPTH),
		.BATCH_TRIPLETS (BATCH_TRIPLETS),
		.FLUSH_LIMIT    (FLUSH_LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

// ===== sv/ctb_ctrl.sv =====
// Controller state machine of the caption triplet batcher
`default_nettype none

module ctb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctb_pkg::ctb_sts_t sts,
	output ctb_pkg::ctb_cmd_t      cmd
);

`include "assert_macros.svh"

	ctb_pkg::ctb_state_t state_q;
	ctb_pkg::ctb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctb_pkg::ST_IDLE: begin
				if (sts.item_valid && sts.slot_free && sts.item_frame && sts.release_hit) begin
					state_d = ctb_pkg::ST_EMIT;
				end
			end
			ctb_pkg::ST_EMIT: begin
				if (sts.slot_free && sts.last_emit) begin
					state_d = ctb_pkg::ST_IDLE;
				end
			end
			default: state_d = ctb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ctb_pkg::ST_IDLE: begin
				cmd.ready        = sts.slot_free;
				cmd.take_triplet = sts.item_valid && sts.slot_free && !sts.item_frame;
				cmd.take_frame   = sts.item_valid && sts.slot_free && sts.item_frame;
			end
			ctb_pkg::ST_EMIT: begin
				cmd.emit = sts.slot_free;
			end
			default: cmd = '0;
		endcase
	end

	`CTB_ASSERT(a_release_enters_emit, cmd.take_frame && sts.release_hit |=> state_q == ctb_pkg::ST_EMIT, "release did not start a drain")
	`CTB_ASSERT_NEVER(a_no_take_in_emit, (state_q == ctb_pkg::ST_EMIT) && (cmd.take_frame || cmd.take_triplet), "input taken during a drain")
	`CTB_ASSERT(a_last_returns_idle, cmd.emit && sts.last_emit |=> state_q == ctb_pkg::ST_IDLE, "drain did not end on its last triplet")

endmodule

`default_nettype wire

// ===== sv/ctb_datapath.sv =====
// Datapath of the caption triplet batcher: queue memory, counters and output register
`default_nettype none

module ctb_datapath #(
	parameter int QUEUE_DEPTH    = 512,
	parameter int BATCH_TRIPLETS = 20,
	parameter int FLUSH_LIMIT    = 320
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctb_pkg::ctb_cmd_t cmd,
	output ctb_pkg::ctb_sts_t      sts,
	input  wire logic              s_tvalid,
	input  wire logic [23:0]       s_tdata,
	input  wire logic [0:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [23:0]            m_tdata,
	output logic [2:0]             m_tuser,
	output logic                   m_tlast,
	input  wire logic              cfg_valid,
	input  wire logic [15:0]       cfg_data
);

`include "assert_macros.svh"

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int RW = $clog2(BATCH_TRIPLETS + 1);

	logic [23:0]   mem [QUEUE_DEPTH];
	logic [23:0]   rdata_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [FW-1:0] fill_q;
	logic [15:0]   frame_q;
	logic [15:0]   ratio_q;
	logic [RW-1:0] rem_q;
	logic          flush_q;

	logic          out_valid_q;
	logic [23:0]   out_data_q;
	logic          out_has_q;
	logic          out_last_q;
	logic          out_flush_q;
	logic          out_drop_q;

	logic          slot_free;
	logic [15:0]   frame_inc;
	logic          ratio_hit;
	logic          release_hit;
	logic          marker_ok;
	logic          full;
	logic [FW-1:0] batch_n;
	logic          flush_c;
	logic          fetch;
	logic [AW-1:0] rd_next;
	logic [AW-1:0] wr_next;

	assign slot_free   = !out_valid_q || m_tready;
	assign frame_inc   = frame_q + 16'd1;
	assign ratio_hit   = frame_inc >= ratio_q;
	assign release_hit = ratio_hit && (fill_q != '0);
	assign marker_ok   = s_tdata[7:2] == ctb_pkg::MARKER_BITS;
	assign full        = fill_q >= FW'(QUEUE_DEPTH);
	assign batch_n     = (fill_q < FW'(BATCH_TRIPLETS)) ? fill_q : FW'(BATCH_TRIPLETS);
	assign flush_c     = 32'(fill_q - batch_n) > 32'(FLUSH_LIMIT);
	assign rd_next     = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_next     = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	// Fetch on a releasing frame end and on every emit but the last
	assign fetch       = (cmd.take_frame && release_hit) || (cmd.emit && rem_q > RW'(1));

	assign sts.item_valid  = s_tvalid;
	assign sts.item_frame  = s_tuser[0] == ctb_pkg::MODE_FRAME_END;
	assign sts.release_hit = release_hit;
	assign sts.slot_free   = slot_free;
	assign sts.last_emit   = rem_q == RW'(1);

	always_ff @(posedge clk) begin
		if (cmd.take_triplet && marker_ok && !full) begin
			mem[wr_ptr_q] <= s_tdata;
		end
		if (fetch) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			frame_q  <= '0;
			ratio_q  <= 16'd1;
			rem_q    <= '0;
			flush_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ratio_q <= cfg_data;
			end
			if (cmd.take_triplet && marker_ok && !full) begin
				wr_ptr_q <= wr_next;
				fill_q   <= fill_q + 1'b1;
			end
			if (cmd.take_frame) begin
				frame_q <= ratio_hit ? '0 : frame_inc;
				if (release_hit) begin
					rem_q    <= RW'(batch_n);
					flush_q  <= flush_c;
					rd_ptr_q <= rd_next;
					fill_q   <= fill_q - 1'b1;
				end
			end
			if (cmd.emit) begin
				rem_q <= rem_q - 1'b1;
				if (rem_q > RW'(1)) begin
					rd_ptr_q <= rd_next;
					fill_q   <= fill_q - 1'b1;
				end else if (flush_q) begin
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
					fill_q   <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take_triplet || cmd.take_frame || cmd.emit) begin
			out_valid_q <= !(cmd.take_frame && release_hit);
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_triplet) begin
			out_data_q  <= '0;
			out_has_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_flush_q <= 1'b0;
			out_drop_q  <= marker_ok && full;
		end else if (cmd.take_frame && !release_hit) begin
			out_data_q  <= '0;
			out_has_q   <= 1'b0;
			out_last_q  <= 1'b1;
			out_flush_q <= 1'b0;
			out_drop_q  <= 1'b0;
		end else if (cmd.emit) begin
			out_data_q  <= rdata_q;
			out_has_q   <= 1'b1;
			out_last_q  <= rem_q == RW'(1);
			out_flush_q <= (rem_q == RW'(1)) && flush_q;
			out_drop_q  <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_drop_q, out_flush_q, out_has_q};
	assign m_tlast  = out_last_q;

	`CTB_ASSERT_NEVER(a_fill_bound, fill_q > FW'(QUEUE_DEPTH), "fill count above queue depth")
	`CTB_ASSERT_NEVER(a_emit_nothing, cmd.emit && rem_q == '0, "emit with no triplet fetched")
	`CTB_ASSERT(a_stall_holds, out_valid_q && !m_tready |=> out_valid_q && $stable(out_data_q), "result lost under stall")

endmodule

`default_nettype wire

// ===== sim/caption_batch_checker.sv =====
// Checker of the caption triplet batcher: predicts every result and compares it
module caption_batch_checker #(
	parameter int QUEUE_DEPTH    = 512,
	parameter int BATCH_TRIPLETS = 20,
	parameter int FLUSH_LIMIT    = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // cc_byte0 [7:0], cc_byte1 [15:8], cc_byte2 [23:16]
	input  logic [0:0]  s_tuser,   // mode [0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // out_byte0 [7:0], out_byte1 [15:8], out_byte2 [23:16]
	input  logic [2:0]  m_tuser,   // has_triplet [0], flushed [1], dropped_full [2]
	input  logic        m_tlast,   // last_of_frame
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,  // frame_ratio
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic       has_triplet;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic       last_of_frame;
		logic       flushed;
		logic       dropped_full;
	} caption_result_t;

	caption_result_t batch_results[$];
	logic [23:0]     triplet_mem [QUEUE_DEPTH];
	int unsigned     rd_slot;
	int unsigned     wr_slot;
	int unsigned     queued;
	logic [15:0]     frames_seen;
	logic [15:0]     frame_ratio;
	int unsigned     results_seen;

	initial begin
		fail_count = 0;
		outstanding = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < PRINT_CAP)
			$display("%0t ns: result %0d: %s is %0h, expected %0h",
				$time, results_seen, what, got, want);
		fail_count++;
	endtask

	// Work out the results that one accepted input transaction causes
	task automatic predict_item(input logic mode, input logic [23:0] data);
		caption_result_t r;
		int unsigned     n;
		logic            flush;
		r = '0;
		if (mode == ctb_pkg::MODE_TRIPLET) begin
			if (data[7:2] == ctb_pkg::MARKER_BITS) begin
				if (queued < QUEUE_DEPTH) begin
					triplet_mem[wr_slot] = {data[7:0], data[15:8], data[23:16]};
					wr_slot = (wr_slot + 1 >= QUEUE_DEPTH) ? 0 : wr_slot + 1;
					queued++;
				end else begin
					r.dropped_full = 1'b1;
				end
			end
			batch_results.push_back(r);
		end else begin
			frames_seen = frames_seen + 16'd1;
			if (frames_seen < frame_ratio || queued == 0) begin
				if (frames_seen >= frame_ratio)
					frames_seen = '0;
				r.last_of_frame = 1'b1;
				batch_results.push_back(r);
			end else begin
				frames_seen = '0;
				n = (queued < BATCH_TRIPLETS) ? queued : BATCH_TRIPLETS;
				flush = (queued - n) > FLUSH_LIMIT;
				for (int unsigned k = 0; k < n; k++) begin
					r = '0;
					r.has_triplet = 1'b1;
					{r.byte0, r.byte1, r.byte2} = triplet_mem[rd_slot];
					rd_slot = (rd_slot + 1 >= QUEUE_DEPTH) ? 0 : rd_slot + 1;
					queued--;
					r.last_of_frame = (k + 1 == n);
					r.flushed = r.last_of_frame & flush;
					batch_results.push_back(r);
				end
				if (flush) begin
					rd_slot = 0;
					wr_slot = 0;
					queued = 0;
				end
			end
		end
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic check_result();
		caption_result_t want;
		caption_result_t got;
		got = {m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
			m_tlast, m_tuser[1], m_tuser[2]};
		if (batch_results.size() == 0) begin
			report_mismatch("unexpected result, data", int'(got), 0);
		end else begin
			want = batch_results.pop_front();
			if (got.has_triplet !== want.has_triplet)
				report_mismatch("has_triplet", got.has_triplet, want.has_triplet);
			if (got.byte0 !== want.byte0)
				report_mismatch("out_byte0", got.byte0, want.byte0);
			if (got.byte1 !== want.byte1)
				report_mismatch("out_byte1", got.byte1, want.byte1);
			if (got.byte2 !== want.byte2)
				report_mismatch("out_byte2", got.byte2, want.byte2);
			if (got.last_of_frame !== want.last_of_frame)
				report_mismatch("last_of_frame", got.last_of_frame, want.last_of_frame);
			if (got.flushed !== want.flushed)
				report_mismatch("flushed", got.flushed, want.flushed);
			if (got.dropped_full !== want.dropped_full)
				report_mismatch("dropped_full", got.dropped_full, want.dropped_full);
		end
		results_seen++;
	endtask

	// A result leaving at this edge was caused by an earlier transaction, so compare first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_slot = 0;
			wr_slot = 0;
			queued = 0;
			frames_seen = '0;
			frame_ratio = 16'd1;
			batch_results.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_valid && cfg_ready)
				frame_ratio = cfg_data;
			if (s_tvalid && s_tready)
				predict_item(s_tuser[0], s_tdata);
			outstanding = batch_results.size();
		end
	end

endmodule

// ===== sim/caption_triplet_batcher_tb.sv =====
// Testbench top of the caption triplet batcher: stimulus, idling and verdict
module caption_triplet_batcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Slowest run: ~130 transactions, each at worst 20 results behind the longest receiver stalls,
	// well below this; it only catches a hung block
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // cc_byte0 [7:0], cc_byte1 [15:8], cc_byte2 [23:16]
	logic [0:0]  s_tuser;   // mode [0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // out_byte0 [7:0], out_byte1 [15:8], out_byte2 [23:16]
	logic [2:0]  m_tuser;   // has_triplet [0], flushed [1], dropped_full [2]
	logic        m_tlast;   // last_of_frame
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;  // frame_ratio

	int   fail_count;
	int   outstanding;
	int   cycle_count;
	int   rx_hold;
	logic tx_quiet;
	logic rx_quiet;

	caption_triplet_batcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	caption_batch_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Guard against a hung block
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then a long pause
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Receiver: stall at random on the falling edge, hold ready high in quiet stretches
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else if (!rx_quiet && $urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			rx_hold = pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one transaction, hold it until taken, then idle for a random gap
	task automatic send_item(input logic mode, input logic [23:0] data);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Caption triplet with random bytes; a marked one has the top six bits of byte 0 set
	task automatic send_triplet(input logic marked);
		logic [23:0] data;
		data = 24'($urandom);
		if (marked)
			data[7:2] = ctb_pkg::MARKER_BITS;
		else if (data[7:2] == ctb_pkg::MARKER_BITS)
			data[7] = 1'b0;
		send_item(ctb_pkg::MODE_TRIPLET, data);
	endtask

	// Frame end carries random data that the block must ignore
	task automatic send_frame_end();
		send_item(ctb_pkg::MODE_FRAME_END, 24'($urandom));
	endtask

	// Drop valid and wait until every predicted result has left, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	// Write the frame ratio; only ever called with the block idle
	task automatic write_ratio(input logic [15:0] ratio);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= ratio;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          roll;
		logic [15:0] ratio;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ctb_pkg::MODE_TRIPLET;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		rx_hold   = 0;
		tx_quiet  = 1'b0;
		rx_quiet  = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed, ratio at its reset value of 1
		send_frame_end();                                  // nothing queued: one empty result
		send_item(ctb_pkg::MODE_TRIPLET, 24'hFF_00_FC);    // lowest marked byte 0
		send_item(ctb_pkg::MODE_TRIPLET, 24'h00_FF_FF);    // all ones in byte 0 and 1
		send_item(ctb_pkg::MODE_TRIPLET, 24'h55_AA_FB);    // one marker bit clear: ignored
		send_item(ctb_pkg::MODE_TRIPLET, 24'h34_12_00);    // all zero byte 0: ignored
		send_item(ctb_pkg::MODE_TRIPLET, 24'hFF_FF_7F);    // top bit clear: ignored
		send_item(ctb_pkg::MODE_TRIPLET, 24'hA5_5A_FE);
		send_item(ctb_pkg::MODE_FRAME_END, 24'hFF_FF_FF);  // release three
		send_frame_end();                                  // empty again
		send_item(ctb_pkg::MODE_TRIPLET, 24'h80_01_FD);
		send_frame_end();                                  // batch of one
		settle();

		// Ratio 0 releases on every frame as well
		write_ratio(16'd0);
		send_triplet(1'b1);
		send_frame_end();
		send_frame_end();
		settle();

		// Lower the ratio below the frame count: the next frame end releases at once
		write_ratio(16'd5);
		send_triplet(1'b1);
		send_triplet(1'b1);
		repeat (3) send_frame_end();
		settle();
		write_ratio(16'd2);
		send_frame_end();
		settle();

		// Random phases with well-formed traffic, some noise and a mix of ratios
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: ratio = 16'd1;
				1: ratio = 16'd3;
				2: ratio = 16'd0;
				3: ratio = 16'($urandom_range(2, 4));
				default: ratio = 16'($urandom_range(0, 6));
			endcase
			write_ratio(ratio);
			tx_quiet = (phase == 0) ? 1'b1 : $urandom_range(0, 3) == 0;
			rx_quiet = (phase == 0) ? 1'b1 : $urandom_range(0, 3) == 0;
			for (int n = 0; n < 22; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 65)
					send_triplet(1'b1);
				else if (roll < 78)
					send_triplet(1'b0);
				else
					send_frame_end();
				// Hold the sender until the output side has caught up
				if ((phase == 2 && n == 10) || $urandom_range(0, 99) < 4)
					settle();
			end
			settle();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		settle();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
